/* rtl/nrc_pkg.sv */
// Shared types, codes and constants of the nonce replay cache.
`timescale 1ns / 1ps
package nrc_pkg;

  localparam int NUM_SHARDS_DEF        = 16;
  localparam int ENTRIES_PER_SHARD_DEF = 8;
  localparam int NONCE_BYTES_DEF       = 8;
  localparam int TIME_BITS_DEF         = 32;

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;

  localparam logic [3:0]  MAX_ENTRIES_RST    = 4'd8;
  localparam logic [15:0] LIFETIME_TICKS_RST = 16'd60;

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_PURGE = 2'd2;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_REPLAY   = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic REG_MAX_ENTRIES    = 1'b0;
  localparam logic REG_LIFETIME_TICKS = 1'b1;

  typedef enum logic [2:0] {
    NRC_IDLE,
    NRC_HASH,
    NRC_WALK,
    NRC_DECIDE,
    NRC_PURGE
  } nrc_state_t;

  typedef struct packed {
    logic        head_live;
    logic [63:0] hash;
  } nrc_hash_stat_t;

  // One FNV-1a round over the lowercase hex character of a digit.
  // The prime is 2^40 + 0x1b3, so the product is a sum of shifts.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [3:0] digit);
    logic [7:0]  c;
    logic [63:0] x;
    begin
      c = (digit < 4'd10) ? (8'h30 + {4'd0, digit}) : (8'h57 + {4'd0, digit});
      x = h ^ {56'd0, c};
      fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    end
  endfunction

endpackage

/* rtl/nonce_replay_cache_unit.sv */
// Top level of the nonce replay cache: control, entry store and config port.
`timescale 1ns / 1ps
// Check transaction: the digit chain hashes the key (one hex digit per cycle), then the shard
//   walk reads its entries (one entry read per cycle through the registered RAM port) before
//   the done strobe. One check is in flight at a time.
// Purge transaction: sweeps every slot, one slot per cycle.
// Tick transaction: busy never rises. Results cannot be stalled by the receiver.
// Reset (rst, synchronous): table empty via valid flops, time zero, registers to defaults.
module nonce_replay_cache_unit #(
  parameter int NUM_SHARDS        = nrc_pkg::NUM_SHARDS_DEF,
  parameter int ENTRIES_PER_SHARD = nrc_pkg::ENTRIES_PER_SHARD_DEF,
  parameter int NONCE_BYTES       = nrc_pkg::NONCE_BYTES_DEF,
  parameter int TIME_BITS         = nrc_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  input  logic [1:0]  command,
  input  logic [63:0] nonce,
  input  logic [3:0]  key_len,
  output logic        busy,
  output logic        done,
  output logic        accepted,
  output logic [1:0]  status,
  output logic [3:0]  shard
);

  localparam int E     = ENTRIES_PER_SHARD;
  localparam int N     = NUM_SHARDS * ENTRIES_PER_SHARD;
  localparam int AW    = (N > 1) ? $clog2(N) : 1;
  localparam int CNTW  = $clog2(N + 1);
  localparam int KIW   = (E > 1) ? $clog2(E) : 1;
  localparam int NW    = NONCE_BYTES * 8;
  localparam int DW    = TIME_BITS + 4 + NW;

  nrc_pkg::nrc_state_t state, state_next;

  logic [3:0]           max_entries;
  logic [15:0]          lifetime_ticks;
  logic [TIME_BITS-1:0] now_ticks;

  logic [N-1:0]   valid_q;
  logic [NW-1:0]  nonce_q;
  logic [3:0]     len_q;
  logic [AW-1:0]  base_q;
  logic [CNTW-1:0] cnt;
  logic           proc_v;
  logic [AW-1:0]  proc_addr;
  logic [KIW-1:0] proc_k;
  logic [E-1:0]   valid_vec;
  logic [E-1:0]   exp_vec;
  logic           match_q;

  logic           accept_in;
  logic           issue_en;
  logic           ram_we;
  logic [CNTW-1:0] limit;
  logic [AW-1:0]  raddr;
  logic [DW-1:0]  rdata;
  logic [DW-1:0]  wdata;
  logic [AW-1:0]  waddr;
  logic           walk_done;

  // Input conditioning: clamp the length, drop bytes above it, left-align for the chain.
  logic [3:0]    len_c;
  logic [63:0]   nonce_m;
  logic [NW-1:0] nonce_t;
  logic [NW-1:0] aligned;
  logic [6:0]    shamt;

  nrc_pkg::nrc_hash_stat_t hstat;

  assign accept_in = start && !busy;
  assign pready    = 1'b1;

  always_comb begin
    len_c = (key_len > 4'(NONCE_BYTES)) ? 4'(NONCE_BYTES) : key_len;
    for (int b = 0; b < 8; b++) begin
      nonce_m[8*b +: 8] = (4'(b) < len_c) ? nonce[8*b +: 8] : 8'd0;
    end
    nonce_t = nonce_m[NW-1:0];
    shamt   = {4'(NONCE_BYTES) - len_c, 3'b000};
    aligned = nonce_t << shamt;
  end

  nrc_fnv_chain #(
    .NONCE_BYTES (NONCE_BYTES)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .load    (accept_in && (command == nrc_pkg::CMD_CHECK)),
    .aligned (aligned),
    .len     (len_c),
    .stat    (hstat)
  );

  // Entry store: {expiry, length, nonce}; validity lives in valid_q flops.
  nrc_ram #(
    .WIDTH (DW),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries    <= nrc_pkg::MAX_ENTRIES_RST;
      lifetime_ticks <= nrc_pkg::LIFETIME_TICKS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        nrc_pkg::REG_MAX_ENTRIES:    max_entries    <= pwdata[3:0];
        nrc_pkg::REG_LIFETIME_TICKS: lifetime_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nrc_pkg::REG_MAX_ENTRIES:    prdata = {28'd0, max_entries};
      nrc_pkg::REG_LIFETIME_TICKS: prdata = {16'd0, lifetime_ticks};
      default:                     prdata = 32'd0;
    endcase
  end

  // Walk / sweep address generation.
  assign limit     = (state == nrc_pkg::NRC_WALK) ? CNTW'(E) : CNTW'(N);
  assign raddr     = base_q + AW'(cnt);
  assign walk_done = (cnt == limit) && !proc_v;

  // Read-side evaluation of the entry coming out of the RAM.
  logic [NW-1:0]        rd_nonce;
  logic [3:0]           rd_len;
  logic [TIME_BITS-1:0] rd_expiry;
  logic [TIME_BITS-1:0] diff;
  logic                 rd_valid;
  logic                 rd_expired;

  assign rd_nonce   = rdata[NW-1:0];
  assign rd_len     = rdata[NW +: 4];
  assign rd_expiry  = rdata[NW+4 +: TIME_BITS];
  assign diff       = now_ticks - rd_expiry;
  assign rd_expired = !diff[TIME_BITS-1];
  assign rd_valid   = valid_q[proc_addr];

  // Decision at the end of the walk.
  logic [6:0]   fill, expcnt, cap;
  logic         full, still_full, found;
  logic [E-1:0] avail;
  logic [E-1:0] purge_row;
  logic [E-1:0] set_row;
  logic [KIW-1:0] free_k;
  logic [1:0]   verdict;

  always_comb begin
    fill   = 7'd0;
    expcnt = 7'd0;
    for (int k = 0; k < E; k++) begin
      fill   = fill + 7'(valid_vec[k]);
      expcnt = expcnt + 7'(valid_vec[k] & exp_vec[k]);
    end
    cap        = ({3'd0, max_entries} > 7'(E)) ? 7'(E) : {3'd0, max_entries};
    full       = fill >= cap;
    still_full = (fill - expcnt) >= cap;
    purge_row  = (!match_q && full) ? (valid_vec & exp_vec) : '0;
    avail      = ~valid_vec | purge_row;
    found      = 1'b0;
    free_k     = '0;
    for (int k = E - 1; k >= 0; k--) begin
      if (avail[k]) begin
        found  = 1'b1;
        free_k = KIW'(k);
      end
    end
    if (match_q) begin
      verdict = nrc_pkg::STATUS_REPLAY;
    end else if ((full && still_full) || !found) begin
      verdict = nrc_pkg::STATUS_FULL;
    end else begin
      verdict = nrc_pkg::STATUS_ACCEPTED;
    end
    set_row = '0;
    if (verdict == nrc_pkg::STATUS_ACCEPTED) begin
      set_row[free_k] = 1'b1;
    end
  end

  assign waddr = base_q + AW'(free_k);
  assign wdata = {now_ticks + TIME_BITS'(lifetime_ticks), len_q, nonce_q};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      nrc_pkg::NRC_IDLE: begin
        if (start) begin
          case (command)
            nrc_pkg::CMD_CHECK: state_next = nrc_pkg::NRC_HASH;
            nrc_pkg::CMD_PURGE: state_next = nrc_pkg::NRC_PURGE;
            default:            state_next = nrc_pkg::NRC_IDLE;
          endcase
        end
      end
      nrc_pkg::NRC_HASH: begin
        if (!hstat.head_live) state_next = nrc_pkg::NRC_WALK;
      end
      nrc_pkg::NRC_WALK: begin
        if (walk_done) state_next = nrc_pkg::NRC_DECIDE;
      end
      nrc_pkg::NRC_DECIDE: state_next = nrc_pkg::NRC_IDLE;
      nrc_pkg::NRC_PURGE: begin
        if (walk_done) state_next = nrc_pkg::NRC_IDLE;
      end
      default: state_next = nrc_pkg::NRC_IDLE;
    endcase
  end

  // State-decoded controls.
  always_comb begin
    busy     = 1'b1;
    issue_en = 1'b0;
    ram_we   = 1'b0;
    case (state)
      nrc_pkg::NRC_IDLE:   busy = 1'b0;
      nrc_pkg::NRC_HASH:   ;
      nrc_pkg::NRC_WALK:   issue_en = cnt < limit;
      nrc_pkg::NRC_DECIDE: ram_we = (verdict == nrc_pkg::STATUS_ACCEPTED);
      nrc_pkg::NRC_PURGE:  issue_en = cnt < limit;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nrc_pkg::NRC_IDLE;
      now_ticks <= '0;
      valid_q   <= '0;
      proc_v    <= 1'b0;
      done      <= 1'b0;
    end else begin
      state  <= state_next;
      proc_v <= issue_en;
      done   <= 1'b0;

      // Tick advances time at accept; no result.
      if (accept_in && (command == nrc_pkg::CMD_TICK)) begin
        now_ticks <= now_ticks + 1'b1;
      end

      // Sweep over all slots: drop valid entries whose expiry has passed.
      if ((state == nrc_pkg::NRC_PURGE) && proc_v && rd_valid && rd_expired) begin
        valid_q[proc_addr] <= 1'b0;
      end

      // Apply the shard purge and the new entry in one step.
      if (state == nrc_pkg::NRC_DECIDE) begin
        valid_q <= (valid_q & ~(N'(purge_row) << base_q)) | (N'(set_row) << base_q);
        done    <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      nonce_q <= nonce_t;
      len_q   <= len_c;
      cnt     <= '0;
      base_q  <= '0;
    end
    if ((state == nrc_pkg::NRC_HASH) && !hstat.head_live) begin
      base_q  <= AW'(hstat.hash[AW-1:0] & AW'(NUM_SHARDS - 1)) * AW'(E);
      shard   <= 4'(hstat.hash & 64'(NUM_SHARDS - 1));
      cnt     <= '0;
      match_q <= 1'b0;
    end
    if (issue_en) begin
      cnt <= cnt + 1'b1;
    end
    proc_addr <= raddr;
    proc_k    <= KIW'(cnt);
    if ((state == nrc_pkg::NRC_WALK) && proc_v) begin
      valid_vec[proc_k] <= rd_valid;
      exp_vec[proc_k]   <= rd_expired;
      if (rd_valid && (rd_len == len_q) && (rd_nonce == nonce_q)) begin
        match_q <= 1'b1;
      end
    end
    if (state == nrc_pkg::NRC_DECIDE) begin
      status   <= verdict;
      accepted <= (verdict == nrc_pkg::STATUS_ACCEPTED);
    end
  end

  // A result appears only right after the decision cycle.
  a_done_after_decide: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == nrc_pkg::NRC_DECIDE))
    else $error("result strobe without a decision");

  a_accept_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (accepted == (status == nrc_pkg::STATUS_ACCEPTED)))
    else $error("accepted flag disagrees with status");

  a_check_starts_hash: assert property (@(posedge clk) disable iff (rst)
    (accept_in && (command == nrc_pkg::CMD_CHECK)) |=> (state == nrc_pkg::NRC_HASH))
    else $error("check transaction did not enter hashing");

  a_proc_follows_issue: assert property (@(posedge clk) disable iff (rst)
    proc_v |-> $past(issue_en))
    else $error("entry evaluated without a read issued");

endmodule

/* rtl/nrc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/nrc_digit_cell.sv */
// One cell of the hex digit chain: holds a digit and passes it toward the head.
`timescale 1ns / 1ps
module nrc_digit_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [3:0] load_digit,
  input  logic       load_live,
  input  logic [3:0] nbr_digit,
  input  logic       nbr_live,
  output logic [3:0] digit,
  output logic       live
);

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (load) begin
      live <= load_live;
    end else begin
      live <= nbr_live;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digit <= load_digit;
    end else begin
      digit <= nbr_digit;
    end
  end

endmodule

/* rtl/nrc_fnv_chain.sv */
// Hex digit chain feeding one FNV-1a round per cycle.
`timescale 1ns / 1ps
module nrc_fnv_chain #(
  parameter int NONCE_BYTES = nrc_pkg::NONCE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [NONCE_BYTES*8-1:0]   aligned,
  input  logic [3:0]                 len,
  output nrc_pkg::nrc_hash_stat_t    stat
);

  localparam int DigitCount = 2 * NONCE_BYTES;

  logic [3:0]        digit [DigitCount+1];
  logic [DigitCount:0] live;
  logic [63:0]       hash;

  assign digit[DigitCount] = 4'd0;
  assign live[DigitCount]  = 1'b0;

  for (genvar j = 0; j < DigitCount; j++) begin : g_cell
    nrc_digit_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (load),
      .load_digit (aligned[(DigitCount-1-j)*4 +: 4]),
      .load_live  (5'(j) < {len, 1'b0}),
      .nbr_digit  (digit[j+1]),
      .nbr_live   (live[j+1]),
      .digit      (digit[j]),
      .live       (live[j])
    );
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hash <= nrc_pkg::FNV_OFFSET;
    end else if (live[0]) begin
      hash <= nrc_pkg::fnv_step(hash, digit[0]);
    end
  end

  assign stat.head_live = live[0];
  assign stat.hash      = hash;

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the nonce replay cache unit.
`timescale 1ns / 1ps
module tb_top;

  localparam int          SHARDS       = 16;
  localparam int          WAYS         = 8;
  localparam logic [63:0] FNV_PRIME    = 64'h100000001b3;
  localparam logic [1:0]  CMD_RESERVED = 2'd3;
  localparam int          QUIET_WAIT   = 160;   // covers a full purge sweep
  localparam int          STALL_MAX    = 5000;

  typedef struct {
    bit          is_cfg;
    logic        reg_sel;
    logic [31:0] value;
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [3:0]  len;
  } job_t;

  typedef struct {
    logic       acc;
    logic [1:0] stat;
    logic [3:0] shd;
  } verdict_t;

  typedef struct {
    logic [63:0] key;
    logic [3:0]  len;
  } key_t;

  typedef enum logic [1:0] {DRV_RUN, DRV_DRAIN, DRV_ACCESS, DRV_RELEASE} drv_state_t;

  logic        clk, rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        start, busy, done, accepted;
  logic [1:0]  command, status;
  logic [63:0] nonce;
  logic [3:0]  key_len, shard;

  nonce_replay_cache_unit u_top (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Shadow copy of the cache state and its registers.
  logic [3:0]  cap_reg;
  logic [15:0] life_reg;
  logic [31:0] now_cnt;
  bit          slot_live [SHARDS*WAYS];
  logic [63:0] slot_key  [SHARDS*WAYS];
  logic [3:0]  slot_len  [SHARDS*WAYS];
  logic [31:0] slot_exp  [SHARDS*WAYS];
  int          fill      [SHARDS];

  job_t       pending_jobs[$];
  verdict_t   verdicts_due[$];
  key_t       seen_keys[$];
  drv_state_t drv;
  int         quiet_cnt, taken_cnt, mismatches, stall_cnt;

  function automatic bit is_stale(logic [31:0] exp_at);
    logic [31:0] diff;
    diff = now_cnt - exp_at;
    return !diff[31];
  endfunction

  task automatic sweep_shard(int s);
    for (int k = 0; k < WAYS; k++)
      if (slot_live[s*WAYS+k] && is_stale(slot_exp[s*WAYS+k])) begin
        slot_live[s*WAYS+k] = 0;
        if (fill[s] > 0) fill[s]--;
      end
  endtask

  // Advance the shadow state by one transaction; queue a verdict for checks.
  task automatic predict_cache(job_t j);
    logic [63:0] k, h;
    logic [3:0]  n, s;
    logic [7:0]  b, c;
    logic [3:0]  dig;
    int          cap, free_at;
    verdict_t    v;
    if (j.cmd == nrc_pkg::CMD_TICK) begin
      now_cnt = now_cnt + 1;
      return;
    end
    if (j.cmd == nrc_pkg::CMD_PURGE) begin
      for (int i = 0; i < SHARDS; i++) sweep_shard(i);
      return;
    end
    if (j.cmd != nrc_pkg::CMD_CHECK) return;
    n = (j.len > 8) ? 4'd8 : j.len;
    k = (n == 8) ? j.key : (j.key & ((64'd1 << (8*n)) - 1));
    h = nrc_pkg::FNV_OFFSET;
    for (int i = 0; i < n; i++) begin
      b = 8'(k >> (8*(n-1-i)));
      for (int d = 0; d < 2; d++) begin
        dig = d ? b[3:0] : b[7:4];
        c = (dig < 10) ? 8'h30 + dig : 8'h57 + dig;
        h = (h ^ c) * FNV_PRIME;
      end
    end
    s = h[3:0];
    v.shd = s;
    v.acc = 0;
    for (int w = 0; w < WAYS; w++)
      if (slot_live[s*WAYS+w] && slot_len[s*WAYS+w] == n && slot_key[s*WAYS+w] == k) begin
        v.stat = nrc_pkg::STATUS_REPLAY;
        verdicts_due.push_back(v);
        return;
      end
    cap = (cap_reg > WAYS) ? WAYS : cap_reg;
    if (fill[s] >= cap) begin
      sweep_shard(s);
      if (fill[s] >= cap) begin
        v.stat = nrc_pkg::STATUS_FULL;
        verdicts_due.push_back(v);
        return;
      end
    end
    free_at = -1;
    for (int w = WAYS-1; w >= 0; w--)
      if (!slot_live[s*WAYS+w]) free_at = s*WAYS+w;
    if (free_at < 0) begin
      v.stat = nrc_pkg::STATUS_FULL;
    end else begin
      slot_live[free_at] = 1;
      slot_key[free_at]  = k;
      slot_len[free_at]  = n;
      slot_exp[free_at]  = now_cnt + life_reg;
      fill[s]++;
      v.acc  = 1;
      v.stat = nrc_pkg::STATUS_ACCEPTED;
    end
    verdicts_due.push_back(v);
  endtask

  // Driver: present queued transactions on start, register writes over APB.
  always @(posedge clk) begin
    if (rst) begin
      start <= 0; command <= nrc_pkg::CMD_CHECK; nonce <= '0; key_len <= '0;
      psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
      drv <= DRV_RUN; quiet_cnt <= 0; taken_cnt <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == nrc_pkg::REG_LIFETIME_TICKS) life_reg = pwdata[15:0];
        else cap_reg = pwdata[3:0];
      end
      if (start && !busy) begin
        predict_cache(pending_jobs[0]);
        void'(pending_jobs.pop_front());
        taken_cnt <= taken_cnt + 1;
      end
      case (drv)
        DRV_RUN: begin
          if (!(start && busy)) begin
            if (pending_jobs.size() == 0) begin
              start <= 0;
            end else if (pending_jobs[0].is_cfg) begin
              start <= 0; quiet_cnt <= 0; drv <= DRV_DRAIN;
            end else if ((taken_cnt < 250 || taken_cnt > 400) && $urandom_range(99) < 23) begin
              start <= 0;
            end else begin
              start     <= 1;
              command   <= pending_jobs[0].cmd;
              nonce     <= pending_jobs[0].key;
              key_len   <= pending_jobs[0].len;
            end
          end
        end
        DRV_DRAIN: begin
          // hold off until no verdict is due and the block has gone quiet
          if (verdicts_due.size() != 0 || busy) quiet_cnt <= 0;
          else if (quiet_cnt < QUIET_WAIT) quiet_cnt <= quiet_cnt + 1;
          else begin
            psel   <= 1; pwrite <= 1; penable <= 0;
            paddr  <= {pending_jobs[0].reg_sel, 2'b00};
            pwdata <= pending_jobs[0].value;
            drv    <= DRV_ACCESS;
          end
        end
        DRV_ACCESS: begin
          penable <= 1;
          drv     <= DRV_RELEASE;
        end
        DRV_RELEASE: begin
          psel <= 0; penable <= 0; pwrite <= 0;
          void'(pending_jobs.pop_front());
          drv <= DRV_RUN;
        end
        default: ;
      endcase
    end
  end

  // Monitor: every done strobe carries one verdict; compare with the oldest due.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: accepted=%0d status=%0d shard=%0d",
                   accepted, status, shard);
      end else begin
        if (accepted !== verdicts_due[0].acc || status !== verdicts_due[0].stat ||
            shard !== verdicts_due[0].shd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected acc=%0d st=%0d sh=%0d, got acc=%0d st=%0d sh=%0d",
                     verdicts_due[0].acc, verdicts_due[0].stat, verdicts_due[0].shd,
                     accepted, status, shard);
        end
        void'(verdicts_due.pop_front());
      end
    end
  end

  // Watchdog: count cycles with no transaction moving.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_MAX) begin
      $display("** nonce_replay_cache_unit: FAILED **");
      $finish;
    end
  end

  task automatic add_job(logic [1:0] c, logic [63:0] k, logic [3:0] n);
    job_t j;
    j = '{is_cfg: 0, reg_sel: 0, value: 0, cmd: c, key: k, len: n};
    pending_jobs.push_back(j);
    if (c == nrc_pkg::CMD_CHECK) seen_keys.push_back('{key: k, len: n});
  endtask

  task automatic add_cfg(logic [3:0] cap, logic [15:0] life);
    pending_jobs.push_back('{is_cfg: 1, reg_sel: nrc_pkg::REG_MAX_ENTRIES,
                             value: {28'd0, cap}, cmd: nrc_pkg::CMD_CHECK, key: 0, len: 0});
    pending_jobs.push_back('{is_cfg: 1, reg_sel: nrc_pkg::REG_LIFETIME_TICKS,
                             value: {16'd0, life}, cmd: nrc_pkg::CMD_CHECK, key: 0, len: 0});
  endtask

  // Mostly checks, with replays of earlier keys, bursts of ticks, sweeps and reserved commands.
  task automatic add_random(int count);
    int   r, pick;
    key_t old;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 30 && seen_keys.size() > 0) begin
        pick = $urandom_range(seen_keys.size() - 1);
        old  = seen_keys[pick];
        // junk above the valid bytes must not matter
        add_job(nrc_pkg::CMD_CHECK, old.key ^ ({$urandom, $urandom} << (8*old.len)),
                (old.len == 8 && $urandom_range(1)) ? 4'(8 + $urandom_range(7)) : old.len);
      end else if (r < 60) begin
        add_job(nrc_pkg::CMD_CHECK, {$urandom, $urandom}, 4'($urandom_range(15)));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 6))
          add_job(nrc_pkg::CMD_TICK, {$urandom, $urandom}, 4'($urandom));
      end else if (r < 96) begin
        add_job(nrc_pkg::CMD_PURGE, {$urandom, $urandom}, 4'($urandom));
      end else begin
        add_job(CMD_RESERVED, {$urandom, $urandom}, 4'($urandom));
      end
      if (seen_keys.size() > 64) void'(seen_keys.pop_front());
    end
  endtask

  initial begin
    cap_reg  = nrc_pkg::MAX_ENTRIES_RST;
    life_reg = nrc_pkg::LIFETIME_TICKS_RST;
    now_cnt  = 0;
    foreach (slot_live[i]) slot_live[i] = 0;
    foreach (fill[i]) fill[i] = 0;
    mismatches = 0;
    rst = 1;

    // directed: empty key, widest key, long length, masking, odd commands
    add_job(nrc_pkg::CMD_CHECK, 64'h0, 4'd0);
    add_job(nrc_pkg::CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    add_job(nrc_pkg::CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    add_job(nrc_pkg::CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    add_job(nrc_pkg::CMD_CHECK, 64'h0, 4'd1);
    add_job(nrc_pkg::CMD_CHECK, 64'hFFFF_FF00, 4'd1);
    add_job(nrc_pkg::CMD_CHECK, 64'h0, 4'd8);
    add_job(nrc_pkg::CMD_CHECK, 64'h0123_4567_89AB_CDEF, 4'd8);
    add_job(CMD_RESERVED, 64'h0123_4567_89AB_CDEF, 4'd8);
    add_job(nrc_pkg::CMD_CHECK, 64'h0123_4567_89AB_CDEF, 4'd8);
    add_job(nrc_pkg::CMD_TICK, 64'h0, 4'd0);
    add_job(nrc_pkg::CMD_PURGE, 64'h0, 4'd0);
    // tiny capacity and lifetime: expired replay, full shard, zero limit
    add_cfg(4'd1, 16'd2);
    add_job(nrc_pkg::CMD_CHECK, 64'hA5, 4'd1);
    repeat (3) add_job(nrc_pkg::CMD_TICK, 64'h0, 4'd0);
    add_job(nrc_pkg::CMD_CHECK, 64'hA5, 4'd1);
    add_job(nrc_pkg::CMD_PURGE, 64'h0, 4'd0);
    add_job(nrc_pkg::CMD_CHECK, 64'hA5, 4'd1);
    add_cfg(4'd0, 16'd0);
    add_job(nrc_pkg::CMD_CHECK, 64'h5A5A, 4'd2);
    add_job(nrc_pkg::CMD_CHECK, 64'h77, 4'd7);

    add_cfg(4'd8, 16'd60);    add_random(70);
    add_cfg(4'd15, 16'd0);    add_random(65);
    add_cfg(4'd3, 16'd65535); add_random(70);
    add_cfg(4'd0, 16'd5);     add_random(35);
    add_cfg(4'd2, 16'd8);     add_random(75);
    add_cfg(4'd8, 16'd20);    add_random(85);

    repeat (3) @(posedge clk);
    rst <= 0;
    do @(posedge clk);
    while (pending_jobs.size() != 0 || verdicts_due.size() != 0 || busy);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("** nonce_replay_cache_unit: PASSED **");
    else
      $display("** nonce_replay_cache_unit: FAILED **");
    $finish;
  end
endmodule
